// ===== rtl/core/rsch_pkg.sv =====
// Shared constants, types and step functions of the ray-sphere closest-hit pipeline.
package rsch_pkg;

	localparam int NUM_SPHERES  = 4;
	localparam int FRAC_BITS    = 16;
	localparam int IDX_W        = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
	localparam int ENTRY_W      = 2;
	localparam int CRD_W        = 32;
	localparam int T_W          = 31;
	localparam logic [T_W-1:0] T_NONE = '1;
	localparam int COEF_W       = 2 * CRD_W;
	localparam int DISC_W       = 2 * COEF_W;
	localparam int ROOT_W       = DISC_W / 2;
	localparam int REM_W        = ROOT_W + 4;
	localparam int SQ_PER_STAGE = 4;
	localparam int SQ_STAGES    = ROOT_W / SQ_PER_STAGE;
	localparam int Q_W          = T_W + 1;
	localparam int DIV_W        = 128;
	localparam int DV_PER_STAGE = 4;
	localparam int DV_STAGES    = Q_W / DV_PER_STAGE;
	localparam int SAT_SHIFT    = T_W - FRAC_BITS;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic             is_load;
		logic             last;
		logic [IDX_W-1:0] idx;
		logic             skip;
		logic [T_W-1:0]   t_min;
		logic [T_W-1:0]   t_max;
	} tag_t;

	typedef struct packed {
		logic [DISC_W-1:0] rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DIV_W-1:0] r_far;
		logic [DIV_W-1:0] r_near;
		logic [DIV_W-1:0] d;
		logic [Q_W-1:0]   q_far;
		logic [Q_W-1:0]   q_near;
	} dv_t;

	// A few digits of the restoring square root, two radicand bits per digit.
	function automatic sq_t sqrt_steps(sq_t s_in);
		sq_t s;
		logic [REM_W-1:0] trial;
		s = s_in;
		for (int j = 0; j < SQ_PER_STAGE; j++) begin
			s.rem = {s.rem[REM_W-3:0], s.rad[DISC_W-1 -: 2]};
			s.rad = {s.rad[DISC_W-3:0], 2'b00};
			trial = REM_W'({s.root, 2'b01});
			if (s.rem >= trial) begin
				s.rem  = s.rem - trial;
				s.root = {s.root[ROOT_W-2:0], 1'b1};
			end else begin
				s.root = {s.root[ROOT_W-2:0], 1'b0};
			end
		end
		return s;
	endfunction

	// A few quotient bits of both roots; the divisor walks down one bit a step.
	function automatic dv_t div_steps(dv_t s_in);
		dv_t s;
		s = s_in;
		for (int j = 0; j < DV_PER_STAGE; j++) begin
			if (s.r_far >= s.d) begin
				s.r_far = s.r_far - s.d;
				s.q_far = {s.q_far[Q_W-2:0], 1'b1};
			end else begin
				s.q_far = {s.q_far[Q_W-2:0], 1'b0};
			end
			if (s.r_near >= s.d) begin
				s.r_near = s.r_near - s.d;
				s.q_near = {s.q_near[Q_W-2:0], 1'b1};
			end else begin
				s.q_near = {s.q_near[Q_W-2:0], 1'b0};
			end
			s.d = s.d >> 1;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/rsch_if.sv =====
// Request and response channel interfaces of the ray-sphere closest-hit block.
interface rsch_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic [rsch_pkg::ENTRY_W-1:0]        entry_index;
	logic signed [rsch_pkg::CRD_W-1:0]   pos_x;
	logic signed [rsch_pkg::CRD_W-1:0]   pos_y;
	logic signed [rsch_pkg::CRD_W-1:0]   pos_z;
	logic signed [rsch_pkg::CRD_W-1:0]   dir_x;
	logic signed [rsch_pkg::CRD_W-1:0]   dir_y;
	logic signed [rsch_pkg::CRD_W-1:0]   dir_z;
	logic [rsch_pkg::T_W-1:0]            radius;
	logic [rsch_pkg::T_W-1:0]            t_min;
	logic [rsch_pkg::T_W-1:0]            t_max;

	modport source (output valid, req_type, entry_index, pos_x, pos_y, pos_z,
		dir_x, dir_y, dir_z, radius, t_min, t_max, input ready);
	modport sink (input valid, req_type, entry_index, pos_x, pos_y, pos_z,
		dir_x, dir_y, dir_z, radius, t_min, t_max, output ready);
endinterface

interface rsch_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [rsch_pkg::ENTRY_W-1:0] hit_index;
	logic [rsch_pkg::T_W-1:0]     hit_t;

	modport source (output valid, hit, hit_index, hit_t, input ready);
	modport sink (input valid, hit, hit_index, hit_t, output ready);
endinterface

// ===== rtl/core/ray_sphere_closest_hit_top.sv =====
// Top level of the ray-sphere closest-hit block.
// Each accepted word is either a sphere load or a ray trace and yields exactly one response
// word, in order. A load takes one issue slot; a trace takes one slot per table entry
// (NUM_SPHERES), since the sphere tests share one pipelined quadratic solver that
// starts one sphere per cycle unless a stalled response holds the whole pipeline in place.
// The solver is 32 register stages deep from the issue slot to the response register:
// one for the issue slot, five for the coefficients and discriminant, sixteen for the
// square root, nine for the two root divisions and one for the nearest-hit selection.
module ray_sphere_closest_hit_top (
	input  logic        clk,
	input  logic        arst_n,
	rsch_req_if.sink    req,
	rsch_rsp_if.source  rsp
);
	logic adv;

	logic                                vld_s1;
	rsch_pkg::tag_t                      tag_s1;
	rsch_pkg::vec_t                      co_s1, dir_s1;
	logic [rsch_pkg::T_W-1:0]            r_s1;

	logic                                vld_s6;
	rsch_pkg::tag_t                      tag_s6;
	logic signed [rsch_pkg::COEF_W-1:0]  a_s6, b_s6;
	logic signed [rsch_pkg::DISC_W-1:0]  disc_s6;

	logic                                sq_vld;
	rsch_pkg::tag_t                      sq_tag;
	logic signed [rsch_pkg::COEF_W-1:0]  sq_a, sq_b;
	logic [rsch_pkg::ROOT_W-1:0]         sq_root;

	logic                                dv_vld, ok_far, ok_near;
	rsch_pkg::tag_t                      dv_tag;
	logic [rsch_pkg::T_W-1:0]            t_far, t_near;

	// advance everything unless a finished word waits
	assign adv = !rsp.valid || rsp.ready;

	rsch_seq u_seq (
		.clk, .arst_n, .req, .adv,
		.vld_s1, .tag_s1, .co_s1, .dir_s1, .r_s1
	);

	rsch_coef u_coef (
		.clk, .arst_n, .adv,
		.vld_s1, .tag_s1, .co_s1, .dir_s1, .r_s1,
		.vld_s6, .tag_s6, .a_s6, .b_s6, .disc_s6
	);

	rsch_sqrt u_sqrt (
		.clk, .arst_n, .adv,
		.in_vld(vld_s6), .in_tag(tag_s6), .in_a(a_s6), .in_b(b_s6), .in_disc(disc_s6),
		.out_vld(sq_vld), .out_tag(sq_tag), .out_a(sq_a), .out_b(sq_b), .out_root(sq_root)
	);

	rsch_div u_div (
		.clk, .arst_n, .adv,
		.in_vld(sq_vld), .in_tag(sq_tag), .in_a(sq_a), .in_b(sq_b), .in_root(sq_root),
		.out_vld(dv_vld), .out_tag(dv_tag), .ok_far, .t_far, .ok_near, .t_near
	);

	rsch_best u_best (
		.clk, .arst_n, .adv,
		.in_vld(dv_vld), .in_tag(dv_tag), .ok_far, .t_far, .ok_near, .t_near, .rsp
	);
endmodule

// ===== rtl/core/rsch_seq.sv =====
// Request intake, sphere table and per-sphere slot issue.
module rsch_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	rsch_req_if.sink                    req,
	input  logic                        adv,
	output logic                        vld_s1,
	output rsch_pkg::tag_t              tag_s1,
	output rsch_pkg::vec_t              co_s1,
	output rsch_pkg::vec_t              dir_s1,
	output logic [rsch_pkg::T_W-1:0]    r_s1
);
	localparam int WIDX_W = rsch_pkg::IDX_W + rsch_pkg::ENTRY_W;

	logic                             busy_q;
	logic                             load_q;
	logic [rsch_pkg::IDX_W-1:0]       cnt_q;
	logic [rsch_pkg::ENTRY_W-1:0]     eidx_q;
	rsch_pkg::vec_t                   org_q;
	rsch_pkg::vec_t                   dir_q;
	logic [rsch_pkg::T_W-1:0]         rad_q;
	logic [rsch_pkg::T_W-1:0]         tmin_q;
	logic [rsch_pkg::T_W-1:0]         tmax_q;
	rsch_pkg::vec_t                   cen_q [rsch_pkg::NUM_SPHERES];
	logic [rsch_pkg::T_W-1:0]         rtab_q [rsch_pkg::NUM_SPHERES];
	logic [rsch_pkg::NUM_SPHERES-1:0] tvld_q;

	logic              last_slot;
	logic              issue;
	logic              accept;
	logic [WIDX_W-1:0] widx;
	logic              in_range;
	logic              do_write;
	rsch_pkg::vec_t    cen;

	function automatic logic signed [rsch_pkg::CRD_W-1:0] sat_sub(
		logic signed [rsch_pkg::CRD_W-1:0] p, logic signed [rsch_pkg::CRD_W-1:0] c);
		logic signed [rsch_pkg::CRD_W:0] d;
		d = {p[rsch_pkg::CRD_W-1], p} - {c[rsch_pkg::CRD_W-1], c};
		if (d[rsch_pkg::CRD_W] != d[rsch_pkg::CRD_W-1]) begin
			return {d[rsch_pkg::CRD_W], {(rsch_pkg::CRD_W-1){~d[rsch_pkg::CRD_W]}}};
		end
		return d[rsch_pkg::CRD_W-1:0];
	endfunction

	assign last_slot = load_q || (cnt_q == rsch_pkg::IDX_W'(rsch_pkg::NUM_SPHERES - 1));
	assign issue     = busy_q && adv;
	assign req.ready = adv && (!busy_q || last_slot);
	assign accept    = req.valid && req.ready;
	assign widx      = WIDX_W'(eidx_q);
	assign in_range  = widx < WIDX_W'(rsch_pkg::NUM_SPHERES);
	assign do_write  = issue && load_q && in_range;
	assign cen       = cen_q[cnt_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			tvld_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (issue) begin
				if (last_slot) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (do_write) begin
				tvld_q[widx[rsch_pkg::IDX_W-1:0]] <= 1'b1;
			end
			if (adv) begin
				vld_s1 <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			load_q <= !req.req_type;
			eidx_q <= req.entry_index;
			org_q  <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
			dir_q  <= '{x: req.dir_x, y: req.dir_y, z: req.dir_z};
			rad_q  <= req.radius;
			tmin_q <= req.t_min;
			tmax_q <= req.t_max;
		end
		if (do_write) begin
			cen_q[widx[rsch_pkg::IDX_W-1:0]]  <= org_q;
			rtab_q[widx[rsch_pkg::IDX_W-1:0]] <= rad_q;
		end
		if (adv) begin
			tag_s1 <= '{is_load: load_q, last: last_slot, idx: cnt_q,
				skip: !tvld_q[cnt_q], t_min: tmin_q, t_max: tmax_q};
			co_s1  <= '{x: sat_sub(org_q.x, cen.x), y: sat_sub(org_q.y, cen.y),
				z: sat_sub(org_q.z, cen.z)};
			dir_s1 <= dir_q;
			r_s1   <= rtab_q[cnt_q];
		end
	end
endmodule

// ===== rtl/core/rsch_coef.sv =====
// Quadratic coefficients and discriminant over five register stages.
module rsch_coef (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 vld_s1,
	input  rsch_pkg::tag_t                       tag_s1,
	input  rsch_pkg::vec_t                       co_s1,
	input  rsch_pkg::vec_t                       dir_s1,
	input  logic [rsch_pkg::T_W-1:0]             r_s1,
	output logic                                 vld_s6,
	output rsch_pkg::tag_t                       tag_s6,
	output logic signed [rsch_pkg::COEF_W-1:0]   a_s6,
	output logic signed [rsch_pkg::COEF_W-1:0]   b_s6,
	output logic signed [rsch_pkg::DISC_W-1:0]   disc_s6
);
	localparam int P_W = 2 * rsch_pkg::CRD_W;
	localparam int H_W = rsch_pkg::COEF_W / 2;

	logic signed [P_W-1:0] m_dx, m_dy, m_dz, m_cdx, m_cdy, m_cdz, m_ccx, m_ccy, m_ccz;
	logic [2*rsch_pkg::T_W-1:0] m_rr;

	logic                                vld_s2, vld_s3, vld_s4, vld_s5;
	rsch_pkg::tag_t                      tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [rsch_pkg::COEF_W-1:0]  dd_s2 [3];
	logic signed [rsch_pkg::COEF_W-1:0]  cd_s2 [3];
	logic signed [rsch_pkg::COEF_W-1:0]  cc_s2 [3];
	logic signed [rsch_pkg::COEF_W-1:0]  rr_s2;
	logic signed [rsch_pkg::COEF_W-1:0]  a_s3, b_s3, c_s3;
	logic signed [rsch_pkg::COEF_W-1:0]  a_s4, b_s4, a_s5, b_s5;
	logic [P_W-1:0]                      bb_ll_s4, bb_lh_s4, bb_hh_s4;
	logic [P_W-1:0]                      ac_ll_s4, ac_lh_s4, ac_hl_s4, ac_hh_s4;
	logic                                ac_neg_s4;
	logic signed [rsch_pkg::DISC_W-1:0]  bb_s5, ac_s5;
	logic [rsch_pkg::COEF_W-1:0]         bm_c, am_c, cm_c;
	logic [rsch_pkg::DISC_W-1:0]         bb_c, acm_c, ac4_c;
	logic signed [rsch_pkg::DISC_W-1:0]  disc_c;
	logic signed [rsch_pkg::COEF_W-1:0]  a_c;
	rsch_pkg::tag_t                      tag3_c, tag6_c;

	assign m_dx  = dir_s1.x * dir_s1.x;
	assign m_dy  = dir_s1.y * dir_s1.y;
	assign m_dz  = dir_s1.z * dir_s1.z;
	assign m_cdx = co_s1.x * dir_s1.x;
	assign m_cdy = co_s1.y * dir_s1.y;
	assign m_cdz = co_s1.z * dir_s1.z;
	assign m_ccx = co_s1.x * co_s1.x;
	assign m_ccy = co_s1.y * co_s1.y;
	assign m_ccz = co_s1.z * co_s1.z;
	assign m_rr  = r_s1 * r_s1;

	assign a_c = dd_s2[0] + dd_s2[1] + dd_s2[2];

	// square and product by halves; a is never negative
	assign bm_c = b_s3[rsch_pkg::COEF_W-1] ? $unsigned(-b_s3) : $unsigned(b_s3);
	assign am_c = $unsigned(a_s3);
	assign cm_c = c_s3[rsch_pkg::COEF_W-1] ? $unsigned(-c_s3) : $unsigned(c_s3);

	assign bb_c  = {bb_hh_s4, bb_ll_s4} + (rsch_pkg::DISC_W'(bb_lh_s4) << (H_W + 1));
	assign acm_c = {ac_hh_s4, ac_ll_s4} + (rsch_pkg::DISC_W'(ac_lh_s4) << H_W)
		+ (rsch_pkg::DISC_W'(ac_hl_s4) << H_W);
	assign ac4_c = acm_c << 2;

	assign disc_c = bb_s5 - ac_s5;

	always_comb begin
		tag3_c      = tag_s2;
		tag3_c.skip = tag_s2.skip || (a_c == '0);
		tag6_c      = tag_s5;
		tag6_c.skip = tag_s5.skip || disc_c[rsch_pkg::DISC_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// floor shift back to Q format
			tag_s2   <= tag_s1;
			dd_s2[0] <= rsch_pkg::COEF_W'(m_dx >>> rsch_pkg::FRAC_BITS);
			dd_s2[1] <= rsch_pkg::COEF_W'(m_dy >>> rsch_pkg::FRAC_BITS);
			dd_s2[2] <= rsch_pkg::COEF_W'(m_dz >>> rsch_pkg::FRAC_BITS);
			cd_s2[0] <= rsch_pkg::COEF_W'(m_cdx >>> rsch_pkg::FRAC_BITS);
			cd_s2[1] <= rsch_pkg::COEF_W'(m_cdy >>> rsch_pkg::FRAC_BITS);
			cd_s2[2] <= rsch_pkg::COEF_W'(m_cdz >>> rsch_pkg::FRAC_BITS);
			cc_s2[0] <= rsch_pkg::COEF_W'(m_ccx >>> rsch_pkg::FRAC_BITS);
			cc_s2[1] <= rsch_pkg::COEF_W'(m_ccy >>> rsch_pkg::FRAC_BITS);
			cc_s2[2] <= rsch_pkg::COEF_W'(m_ccz >>> rsch_pkg::FRAC_BITS);
			rr_s2    <= $signed(rsch_pkg::COEF_W'(m_rr >> rsch_pkg::FRAC_BITS));

			tag_s3 <= tag3_c;
			a_s3   <= a_c;
			b_s3   <= (cd_s2[0] + cd_s2[1] + cd_s2[2]) <<< 1;
			c_s3   <= cc_s2[0] + cc_s2[1] + cc_s2[2] - rr_s2;

			tag_s4    <= tag_s3;
			a_s4      <= a_s3;
			b_s4      <= b_s3;
			bb_ll_s4  <= bm_c[H_W-1:0] * bm_c[H_W-1:0];
			bb_lh_s4  <= bm_c[H_W-1:0] * bm_c[rsch_pkg::COEF_W-1:H_W];
			bb_hh_s4  <= bm_c[rsch_pkg::COEF_W-1:H_W] * bm_c[rsch_pkg::COEF_W-1:H_W];
			ac_ll_s4  <= am_c[H_W-1:0] * cm_c[H_W-1:0];
			ac_lh_s4  <= am_c[H_W-1:0] * cm_c[rsch_pkg::COEF_W-1:H_W];
			ac_hl_s4  <= am_c[rsch_pkg::COEF_W-1:H_W] * cm_c[H_W-1:0];
			ac_hh_s4  <= am_c[rsch_pkg::COEF_W-1:H_W] * cm_c[rsch_pkg::COEF_W-1:H_W];
			ac_neg_s4 <= c_s3[rsch_pkg::COEF_W-1];

			tag_s5 <= tag_s4;
			a_s5   <= a_s4;
			b_s5   <= b_s4;
			bb_s5  <= $signed(bb_c);
			ac_s5  <= ac_neg_s4 ? -$signed(ac4_c) : $signed(ac4_c);

			tag_s6  <= tag6_c;
			a_s6    <= a_s5;
			b_s6    <= b_s5;
			disc_s6 <= disc_c;
		end
	end
endmodule

// ===== rtl/core/rsch_sqrt.sv =====
// Pipelined restoring square root of the discriminant.
module rsch_sqrt (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_vld,
	input  rsch_pkg::tag_t                       in_tag,
	input  logic signed [rsch_pkg::COEF_W-1:0]   in_a,
	input  logic signed [rsch_pkg::COEF_W-1:0]   in_b,
	input  logic signed [rsch_pkg::DISC_W-1:0]   in_disc,
	output logic                                 out_vld,
	output rsch_pkg::tag_t                       out_tag,
	output logic signed [rsch_pkg::COEF_W-1:0]   out_a,
	output logic signed [rsch_pkg::COEF_W-1:0]   out_b,
	output logic [rsch_pkg::ROOT_W-1:0]          out_root
);
	localparam int N = rsch_pkg::SQ_STAGES;

	logic                                vld_s [N];
	rsch_pkg::tag_t                      tag_s [N];
	rsch_pkg::sq_t                       st_s  [N];
	logic signed [rsch_pkg::COEF_W-1:0]  a_s   [N];
	logic signed [rsch_pkg::COEF_W-1:0]  b_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                               pv;
		rsch_pkg::tag_t                     pt;
		rsch_pkg::sq_t                      ps;
		logic signed [rsch_pkg::COEF_W-1:0] pa, pb;

		if (k == 0) begin : g_first
			assign pv = in_vld;
			assign pt = in_tag;
			assign ps = '{rad: $unsigned(in_disc), rem: '0, root: '0};
			assign pa = in_a;
			assign pb = in_b;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign pt = tag_s[k-1];
			assign ps = st_s[k-1];
			assign pa = a_s[k-1];
			assign pb = b_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[k] <= pt;
				st_s[k]  <= rsch_pkg::sqrt_steps(ps);
				a_s[k]   <= pa;
				b_s[k]   <= pb;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign out_tag  = tag_s[N-1];
	assign out_a    = a_s[N-1];
	assign out_b    = b_s[N-1];
	assign out_root = st_s[N-1].root;
endmodule

// ===== rtl/core/rsch_div.sv =====
// Root numerators, range check and pipelined division of both roots by 2a.
module rsch_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_vld,
	input  rsch_pkg::tag_t                       in_tag,
	input  logic signed [rsch_pkg::COEF_W-1:0]   in_a,
	input  logic signed [rsch_pkg::COEF_W-1:0]   in_b,
	input  logic [rsch_pkg::ROOT_W-1:0]          in_root,
	output logic                                 out_vld,
	output rsch_pkg::tag_t                       out_tag,
	output logic                                 ok_far,
	output logic [rsch_pkg::T_W-1:0]             t_far,
	output logic                                 ok_near,
	output logic [rsch_pkg::T_W-1:0]             t_near
);
	localparam int N = rsch_pkg::DV_STAGES;

	logic signed [rsch_pkg::COEF_W-1:0] s_c, num_far, num_near;
	logic [rsch_pkg::DIV_W-1:0]         den, nf_u, nn_u, lim;
	logic                               okf_c, okn_c;

	logic            vld_s0;
	rsch_pkg::tag_t  tag_s0;
	rsch_pkg::dv_t   st_s0;
	logic            okf_s0, okn_s0;

	logic            vld_s [N];
	rsch_pkg::tag_t  tag_s [N];
	rsch_pkg::dv_t   st_s  [N];
	logic            okf_s [N];
	logic            okn_s [N];

	assign s_c      = $signed(rsch_pkg::COEF_W'(in_root));
	assign num_far  = s_c - in_b;
	assign num_near = -in_b - s_c;
	assign den      = rsch_pkg::DIV_W'($unsigned(in_a)) << 1;
	assign nf_u     = rsch_pkg::DIV_W'($unsigned(num_far));
	assign nn_u     = rsch_pkg::DIV_W'($unsigned(num_near));
	assign lim      = den << rsch_pkg::SAT_SHIFT;
	// keep positive roots whose integer part fits; a saturated root is never taken
	assign okf_c    = (num_far > 0) && (nf_u < lim);
	assign okn_c    = (num_near > 0) && (nn_u < lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s0 <= in_tag;
			okf_s0 <= okf_c && !in_tag.skip;
			okn_s0 <= okn_c && !in_tag.skip;
			st_s0  <= '{r_far: nf_u << rsch_pkg::FRAC_BITS, r_near: nn_u << rsch_pkg::FRAC_BITS,
				d: den << (rsch_pkg::Q_W - 1), q_far: '0, q_near: '0};
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic           pv, pf, pn;
		rsch_pkg::tag_t pt;
		rsch_pkg::dv_t  ps;

		if (k == 0) begin : g_first
			assign pv = vld_s0;
			assign pt = tag_s0;
			assign ps = st_s0;
			assign pf = okf_s0;
			assign pn = okn_s0;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign pt = tag_s[k-1];
			assign ps = st_s[k-1];
			assign pf = okf_s[k-1];
			assign pn = okn_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[k] <= pt;
				st_s[k]  <= rsch_pkg::div_steps(ps);
				okf_s[k] <= pf;
				okn_s[k] <= pn;
			end
		end
	end

	assign out_vld = vld_s[N-1];
	assign out_tag = tag_s[N-1];
	assign ok_far  = okf_s[N-1];
	assign ok_near = okn_s[N-1];
	assign t_far   = st_s[N-1].q_far[rsch_pkg::T_W-1:0];
	assign t_near  = st_s[N-1].q_near[rsch_pkg::T_W-1:0];
endmodule

// ===== rtl/core/rsch_best.sv =====
// Running nearest-hit selection over a ray's spheres and the result register.
module rsch_best (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_vld,
	input  rsch_pkg::tag_t            in_tag,
	input  logic                      ok_far,
	input  logic [rsch_pkg::T_W-1:0]  t_far,
	input  logic                      ok_near,
	input  logic [rsch_pkg::T_W-1:0]  t_near,
	rsch_rsp_if.source                rsp
);
	logic                       found_q;
	logic [rsch_pkg::T_W-1:0]   best_q;
	logic [rsch_pkg::IDX_W-1:0] bi_q;

	logic                       start, f0, f1, f2, take_far, take_near, hit_c;
	logic [rsch_pkg::T_W-1:0]   b0, b1, b2;
	logic [rsch_pkg::IDX_W-1:0] i0, i1, i2;

	// restart the running best on the first sphere of a ray
	assign start = (in_tag.idx == '0);
	assign f0    = start ? 1'b0 : found_q;
	assign b0    = start ? rsch_pkg::T_NONE : best_q;
	assign i0    = start ? '0 : bi_q;

	assign take_far = ok_far && (t_far > in_tag.t_min) && (t_far < in_tag.t_max)
		&& (!f0 || (t_far < b0));
	assign f1 = f0 || take_far;
	assign b1 = take_far ? t_far : b0;
	assign i1 = take_far ? in_tag.idx : i0;

	assign take_near = ok_near && (t_near > in_tag.t_min) && (t_near < in_tag.t_max)
		&& (!f1 || (t_near <= b1));
	assign f2 = f1 || take_near;
	assign b2 = take_near ? t_near : b1;
	assign i2 = take_near ? in_tag.idx : i1;

	assign hit_c = !in_tag.is_load && f2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
			found_q   <= 1'b0;
		end else if (adv) begin
			rsp.valid <= in_vld && (in_tag.is_load || in_tag.last);
			if (in_vld && !in_tag.is_load) begin
				found_q <= f2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_vld) begin
			if (!in_tag.is_load) begin
				best_q <= b2;
				bi_q   <= i2;
			end
			rsp.hit       <= hit_c;
			rsp.hit_index <= hit_c ? rsch_pkg::ENTRY_W'(i2) : '0;
			rsp.hit_t     <= hit_c ? b2 : rsch_pkg::T_NONE;
		end
	end
endmodule

// ===== tb/ray_sphere_closest_hit_top_tb.sv =====
// Self-checking testbench for the ray-sphere closest-hit block, with a built-in hit predictor.
`timescale 1ns / 100ps

module ray_sphere_closest_hit_top_tb;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_TRACE = 1'b1;
	localparam int   UNIT      = 1 << rsch_pkg::FRAC_BITS;
	localparam int   DRAIN_CYC = 60;

	typedef struct {
		logic                              req_type;
		logic [rsch_pkg::ENTRY_W-1:0]      entry_index;
		logic signed [rsch_pkg::CRD_W-1:0] pos_x, pos_y, pos_z;
		logic signed [rsch_pkg::CRD_W-1:0] dir_x, dir_y, dir_z;
		logic [rsch_pkg::T_W-1:0]          radius, t_min, t_max;
	} req_word_t;

	typedef struct {
		logic                         hit;
		logic [rsch_pkg::ENTRY_W-1:0] hit_index;
		logic [rsch_pkg::T_W-1:0]     hit_t;
	} hit_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsch_req_if req_if ();
	rsch_rsp_if rsp_if ();

	ray_sphere_closest_hit_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if.sink),
		.rsp   (rsp_if.source)
	);

	always #10 clk = ~clk;

	// Predictor copy of the sphere table.
	longint      tbl_cx [rsch_pkg::NUM_SPHERES];
	longint      tbl_cy [rsch_pkg::NUM_SPHERES];
	longint      tbl_cz [rsch_pkg::NUM_SPHERES];
	longint      tbl_r  [rsch_pkg::NUM_SPHERES];
	bit          tbl_ok [rsch_pkg::NUM_SPHERES];

	hit_word_t   pending_hits[$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint x, longint y);
		return (x * y) >>> rsch_pkg::FRAC_BITS;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] n);
		logic [127:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= n) r = c;
		end
		return r[63:0];
	endfunction

	// Returns 1 when the root is positive; t is the saturated Q quotient.
	function automatic bit root_time(logic signed [127:0] num, logic signed [127:0] den,
			output logic [rsch_pkg::T_W-1:0] t);
		logic signed [127:0] q;
		t = rsch_pkg::T_NONE;
		if (num <= 0) return 1'b0;
		q = (num <<< rsch_pkg::FRAC_BITS) / den;
		t = (q >= 128'sd2147483648) ? rsch_pkg::T_NONE : q[rsch_pkg::T_W-1:0];
		return 1'b1;
	endfunction

	function automatic hit_word_t closest_hit(req_word_t w);
		hit_word_t                res;
		longint                   a, b, c, cx, cy, cz, s;
		logic signed [127:0]      disc;
		logic [rsch_pkg::T_W-1:0] t;
		res = '{1'b0, '0, rsch_pkg::T_NONE};
		if (w.req_type == REQ_LOAD) begin
			tbl_cx[w.entry_index] = w.pos_x;
			tbl_cy[w.entry_index] = w.pos_y;
			tbl_cz[w.entry_index] = w.pos_z;
			tbl_r[w.entry_index]  = longint'(w.radius);
			tbl_ok[w.entry_index] = 1'b1;
			return res;
		end
		a = qmul(w.dir_x, w.dir_x) + qmul(w.dir_y, w.dir_y) + qmul(w.dir_z, w.dir_z);
		for (int i = 0; i < rsch_pkg::NUM_SPHERES; i++) begin
			if (!tbl_ok[i] || a == 0) continue;
			cx = clamp32(longint'(w.pos_x) - tbl_cx[i]);
			cy = clamp32(longint'(w.pos_y) - tbl_cy[i]);
			cz = clamp32(longint'(w.pos_z) - tbl_cz[i]);
			b = 2 * (qmul(cx, w.dir_x) + qmul(cy, w.dir_y) + qmul(cz, w.dir_z));
			c = qmul(cx, cx) + qmul(cy, cy) + qmul(cz, cz) - qmul(tbl_r[i], tbl_r[i]);
			disc = 128'(signed'(b)) * 128'(signed'(b))
				- 128'(signed'(4 * a)) * 128'(signed'(c));
			if (disc < 0) continue;
			s = longint'(floor_sqrt(disc));
			// far root must be strictly nearer, near root may tie
			if (root_time(128'(signed'(-b + s)), 128'(signed'(2 * a)), t)
					&& t > w.t_min && t < w.t_max && (!res.hit || t < res.hit_t))
				res = '{1'b1, rsch_pkg::ENTRY_W'(i), t};
			if (root_time(128'(signed'(-b - s)), 128'(signed'(2 * a)), t)
					&& t > w.t_min && t < w.t_max && (!res.hit || t <= res.hit_t))
				res = '{1'b1, rsch_pkg::ENTRY_W'(i), t};
		end
		return res;
	endfunction

	task automatic send_word(req_word_t w);
		bit lowered;
		lowered = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!lowered) req_if.valid <= 1'b0;
			lowered = 1'b1;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.req_type    <= w.req_type;
		req_if.entry_index <= w.entry_index;
		req_if.pos_x       <= w.pos_x;
		req_if.pos_y       <= w.pos_y;
		req_if.pos_z       <= w.pos_z;
		req_if.dir_x       <= w.dir_x;
		req_if.dir_y       <= w.dir_y;
		req_if.dir_z       <= w.dir_z;
		req_if.radius      <= w.radius;
		req_if.t_min       <= w.t_min;
		req_if.t_max       <= w.t_max;
		do @(posedge clk); while (!req_if.ready);
		pending_hits.push_back(closest_hit(w));
	endtask

	// Check each accepted response word.
	always @(posedge clk) begin
		hit_word_t exp;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: hit=%0d idx=%0d t=%h",
						rsp_if.hit, rsp_if.hit_index, rsp_if.hit_t);
			end else begin
				exp = pending_hits.pop_front();
				if (rsp_if.hit !== exp.hit || rsp_if.hit_index !== exp.hit_index
						|| rsp_if.hit_t !== exp.hit_t) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0d idx=%0d t=%h, got hit=%0d idx=%0d t=%h",
							exp.hit, exp.hit_index, exp.hit_t,
							rsp_if.hit, rsp_if.hit_index, rsp_if.hit_t);
				end
			end
		end
	end

	// Pick the next ready value; hold it low while a long stall counts down.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic req_word_t load_word(int idx, int x, int y, int z, int r);
		req_word_t w;
		w = '{REQ_LOAD, rsch_pkg::ENTRY_W'(idx), x, y, z, 0, 0, 0, rsch_pkg::T_W'(r), 0, 0};
		return w;
	endfunction

	function automatic req_word_t trace_word(int ox, int oy, int oz, int dx, int dy, int dz,
			int tmin, int tmax);
		req_word_t w;
		w = '{REQ_TRACE, '0, ox, oy, oz, dx, dy, dz, '0,
			rsch_pkg::T_W'(tmin), rsch_pkg::T_W'(tmax)};
		return w;
	endfunction

	function automatic req_word_t noise_word();
		req_word_t w;
		w = '{logic'($urandom), rsch_pkg::ENTRY_W'($urandom), $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, rsch_pkg::T_W'($urandom),
			rsch_pkg::T_W'($urandom), rsch_pkg::T_W'($urandom)};
		return w;
	endfunction

	function automatic int near_coord();
		return $urandom_range(32 * UNIT) - 16 * UNIT;
	endfunction

	// Aim a ray from a random origin at one of the table's spheres, scaled and jittered.
	function automatic req_word_t aimed_trace();
		req_word_t w;
		int        tgt, sh;
		tgt = $urandom_range(rsch_pkg::NUM_SPHERES - 1);
		sh  = $urandom_range(4);
		w = trace_word(near_coord(), near_coord(), near_coord(), 0, 0, 0,
			$urandom_range(3) == 0 ? $urandom_range(2 * UNIT) : 0,
			$urandom_range(3) == 0 ? $urandom_range(40 * UNIT) : 32'h7fffffff);
		w.dir_x = (32'(signed'(clamp32(tbl_cx[tgt] - longint'(w.pos_x)))) >>> sh)
			+ int'($urandom_range(UNIT)) - UNIT / 2;
		w.dir_y = (32'(signed'(clamp32(tbl_cy[tgt] - longint'(w.pos_y)))) >>> sh)
			+ int'($urandom_range(UNIT)) - UNIT / 2;
		w.dir_z = (32'(signed'(clamp32(tbl_cz[tgt] - longint'(w.pos_z)))) >>> sh)
			+ int'($urandom_range(UNIT)) - UNIT / 2;
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_hits.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		// empty table: every ray misses
		send_word(trace_word(0, 0, 0, UNIT, 0, 0, 0, 32'h7fffffff));
		send_word(load_word(0, 0, 0, 10 * UNIT, 2 * UNIT));
		send_word(load_word(1, 0, 0, 20 * UNIT, 3 * UNIT));
		// identical spheres: the tie on the near root goes to the later entry
		send_word(load_word(2, 0, 0, 20 * UNIT, 3 * UNIT));
		send_word(load_word(3, 5 * UNIT, 0, 0, UNIT));
		send_word(trace_word(0, 0, 0, 0, 0, UNIT, 0, 32'h7fffffff));
		send_word(trace_word(0, 0, 0, 0, 0, UNIT, 9 * UNIT, 32'h7fffffff));
		send_word(trace_word(0, 0, 0, UNIT, 0, 0, 0, 32'h7fffffff));
		// zero direction, then an empty window
		send_word(trace_word(0, 0, 0, 0, 0, 0, 0, 32'h7fffffff));
		send_word(trace_word(0, 0, 0, 0, 0, UNIT, 5 * UNIT, 5 * UNIT));
		send_word(trace_word(0, 0, 0, 0, 0, UNIT, 20 * UNIT, 3 * UNIT));
		// origin inside a sphere: only the far root is ahead
		send_word(trace_word(0, 0, 10 * UNIT, 0, 0, UNIT, 0, 32'h7fffffff));
		// tiny direction: the root is large but still fits and is accepted
		send_word(trace_word(0, 0, 0, 0, 0, 300, 0, 32'h7fffffff));
		send_word(trace_word(0, 0, 0, 0, 0, -UNIT, 0, 32'h7fffffff));
		send_word(trace_word(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff));
		send_word(trace_word(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_word(load_word(3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
		send_word(trace_word(0, 0, 0, UNIT, -UNIT, UNIT, 0, 32'h7fffffff));
		send_word(trace_word(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff));
		send_word(load_word(3, 5 * UNIT, 0, 0, 0));
		send_word(trace_word(0, 0, 0, UNIT, 0, 0, 0, 32'h7fffffff));
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		int k;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(19))
				0, 1:       send_word(noise_word());
				2, 3, 4:    send_word(load_word($urandom_range(rsch_pkg::NUM_SPHERES - 1),
					near_coord(), near_coord(), near_coord(), $urandom_range(4 * UNIT)));
				default:    send_word(aimed_trace());
			endcase
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		for (int k = 0; k < 40; k++) send_word(aimed_trace());
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.req_type = REQ_LOAD;
		req_if.entry_index = '0;
		req_if.pos_x = '0;
		req_if.pos_y = '0;
		req_if.pos_z = '0;
		req_if.dir_x = '0;
		req_if.dir_y = '0;
		req_if.dir_z = '0;
		req_if.radius = '0;
		req_if.t_min = '0;
		req_if.t_max = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < rsch_pkg::NUM_SPHERES; i++) begin
			tbl_cx[i] = 0; tbl_cy[i] = 0; tbl_cz[i] = 0; tbl_r[i] = 0; tbl_ok[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(180, 0, 0);
		test_random(170, 69, 0);
		test_random(170, 0, 69);
		test_random(170, 10, 10);
		test_backpressure();
		test_random(60, 0, 0);
		// drop valid right at the accepting edge of the last word
		req_if.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rsch_pkg.sv
rtl/core/rsch_if.sv
rtl/core/rsch_seq.sv
rtl/core/rsch_coef.sv
rtl/core/rsch_sqrt.sv
rtl/core/rsch_div.sv
rtl/core/rsch_best.sv
rtl/core/ray_sphere_closest_hit_top.sv
tb/ray_sphere_closest_hit_top_tb.sv
